[rtl/atapio_pkg.sv]
`timescale 1ns / 1ps

package atapio_pkg;

   // geometry
   localparam int WORDS_PER_SECTOR = 256;
   localparam int MAX_SECTORS_WIDE = 65536;
   localparam int WORD_W           = $clog2(WORDS_PER_SECTOR);
   localparam int SECT_W           = $clog2(MAX_SECTORS_WIDE) + 1;
   localparam int ADDR_W           = 48;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int REQ_DATA_W       = 128;
   localparam int RSP_DATA_W       = 72;

   // item kinds carried in tuser
   localparam logic [1:0] OP_START_READ  = 2'd0;
   localparam logic [1:0] OP_START_WRITE = 2'd1;
   localparam logic [1:0] OP_REPLY       = 2'd2;

   // configuration register indexes
   localparam logic CSR_IO_BASE   = 1'b0;
   localparam logic CSR_SECONDARY = 1'b1;

   // task-file register offsets
   localparam logic [15:0] REG_DATA       = 16'h0000;
   localparam logic [15:0] REG_FEATURES   = 16'h0001;
   localparam logic [15:0] REG_COUNT      = 16'h0002;
   localparam logic [15:0] REG_LBA_LOW    = 16'h0003;
   localparam logic [15:0] REG_LBA_MID    = 16'h0004;
   localparam logic [15:0] REG_LBA_HIGH   = 16'h0005;
   localparam logic [15:0] REG_DEVICE     = 16'h0006;
   localparam logic [15:0] REG_CMD_STATUS = 16'h0007;

   // commands and device bytes
   localparam logic [7:0] CMD_READ_PIO      = 8'h20;
   localparam logic [7:0] CMD_WRITE_PIO     = 8'h30;
   localparam logic [7:0] CMD_READ_PIO_EXT  = 8'h24;
   localparam logic [7:0] CMD_WRITE_PIO_EXT = 8'h34;
   localparam logic [7:0] CMD_FLUSH         = 8'hE7;
   localparam logic [7:0] CMD_FLUSH_EXT     = 8'hEA;
   localparam logic [7:0] DEV_LBA28_MASTER  = 8'hE0;
   localparam logic [7:0] DEV_LBA28_SLAVE   = 8'hF0;
   localparam logic [7:0] DEV_LBA48_MASTER  = 8'h40;
   localparam logic [7:0] DEV_LBA48_SLAVE   = 8'h50;

   // status bits
   localparam logic [7:0] STATUS_BSY_ERR_MASK = 8'h81;
   localparam logic [7:0] STATUS_BSY          = 8'h80;

   // setup sequence lengths
   localparam logic [3:0] SETUP_STEPS_NARROW = 4'd7;
   localparam logic [3:0] SETUP_STEPS_WIDE   = 4'd11;

   // classified item passed from front to back
   typedef struct packed {
      logic                is_start;
      logic                is_write;
      logic                out_of_range;
      logic                wide;
      logic [ADDR_W-1:0]   lba;
      logic [SECT_W-1:0]   count_limit;
      logic [15:0]         count_bytes;
      logic [15:0]         read_data;
      logic [15:0]         fill_word;
   } cmd_type;

   // result fields other than the end marker
   typedef struct packed {
      logic                access_valid;
      logic [15:0]         port_address;
      logic                access_write;
      logic                access_wide;
      logic [15:0]         write_value;
      logic                host_word_valid;
      logic [15:0]         host_word;
      logic                fill_taken;
      logic                failed;
      logic [SECT_W-1:0]   sectors_done;
   } rsp_type;

   // port access with all other fields clear
   function automatic rsp_type make_access(input logic [15:0] base, input logic [15:0] off,
                                           input logic wr, input logic wide,
                                           input logic [15:0] val);
      rsp_type r;
      r              = '0;
      r.access_valid = 1'b1;
      r.port_address = base + off;
      r.access_write = wr;
      r.access_wide  = wide;
      r.write_value  = wr ? val : 16'h0000;
      return r;
   endfunction

endpackage

[rtl/ata_pio_transfer_sequencer.sv]
`timescale 1ns / 1ps
// A result is offered from the output register after its item has passed through the queue.
// Throughput: one item per cycle while the output is not stalled; the two-entry queue between
// classifier and sequencer and the output register keep input and output stalls apart.
// Reset (synchronous, active high): sequencer idle, queue and output empty,
// io_base back to 0x01F0 and master drive selected.

module ata_pio_transfer_sequencer
   import atapio_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,  // opcode
   input  logic [REQ_DATA_W-1:0] req_tdata,  // lba, sector_count, read_data, fill_word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tlast,  // done_res
   // access_valid, port_address, access_write, access_wide, write_value, host_word_valid,
   // host_word, fill_taken, failed, sectors_done, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata
);

   logic [15:0] io_base_ff;
   logic        secondary_ff;
   logic        q_valid;
   logic        q_pop;
   cmd_type     q_head;
   rsp_type     rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         io_base_ff   <= 16'h01F0;
         secondary_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IO_BASE:   io_base_ff   <= csr_wdata;
            CSR_SECONDARY: secondary_ff <= csr_wdata[0];
            default:       io_base_ff   <= io_base_ff;
         endcase
      end
   end

   atapio_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   atapio_back u_back (
      .clock           (clock),
      .reset           (reset),
      .io_base         (io_base_ff),
      .secondary_drive (secondary_ff),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_last        (rsp_tlast),
      .rsp_data        (rsp),
      .rsp_ready       (rsp_tready)
   );

   // result packing, first field in the lowest bits
   assign rsp_tdata = {1'b0, rsp.sectors_done, rsp.failed, rsp.fill_taken, rsp.host_word,
                       rsp.host_word_valid, rsp.write_value, rsp.access_wide,
                       rsp.access_write, rsp.port_address, rsp.access_valid};

   // a failure is always the end of a transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.failed |-> rsp_tlast)
      else $error("failed result without end of transfer");

   // the end of a transfer carries no port access
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp.access_valid)
      else $error("port access issued with end of transfer");

   // input held off only while the queue holds items
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_valid)
      else $error("input stalled with empty queue");

   // a word handed to the host always comes from a data-port read
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.host_word_valid |-> !rsp.fill_taken)
      else $error("host word and fill word in the same result");

endmodule

[rtl/atapio_front.sv]
`timescale 1ns / 1ps

module atapio_front
   import atapio_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  q_valid,
   output cmd_type               q_head,
   input  logic                  q_pop
);

   logic [63:0]       lba;
   logic [31:0]       cnt;
   logic              accept;
   logic              push;
   cmd_type           cmd;
   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign lba = req_tdata[63:0];
   assign cnt = req_tdata[95:64];

   // classify the item: mode, range check, clamped count, count register bytes
   always_comb begin
      cmd              = '0;
      cmd.is_start     = (req_tuser == OP_START_READ) || (req_tuser == OP_START_WRITE);
      cmd.is_write     = (req_tuser == OP_START_WRITE);
      cmd.wide         = (lba[63:28] != '0) || (cnt > 32'd256);
      cmd.out_of_range = (lba[63:48] != '0);
      cmd.lba          = lba[ADDR_W-1:0];
      cmd.count_limit  = (cnt > 32'(MAX_SECTORS_WIDE)) ? SECT_W'(MAX_SECTORS_WIDE)
                                                       : cnt[SECT_W-1:0];
      if (cmd.wide) begin
         cmd.count_bytes = (cnt > 32'd65535) ? 16'h0000 : cnt[15:0];
      end else begin
         cmd.count_bytes = (cnt > 32'd255) ? 16'h0000 : {8'h00, cnt[7:0]};
      end
      cmd.read_data    = req_tdata[111:96];
      cmd.fill_word    = req_tdata[127:112];
   end

   // items of no meaning are dropped on acceptance
   assign req_tready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (cmd.is_start || (req_tuser == OP_REPLY));

   assign q_valid = (count_ff != '0);
   assign q_head  = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

[rtl/atapio_back.sv]
`timescale 1ns / 1ps

module atapio_back
   import atapio_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] io_base,
   input  logic        secondary_drive,
   input  logic        q_valid,
   input  cmd_type     q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   output logic        rsp_last,
   output rsp_type     rsp_data,
   input  logic        rsp_ready
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETUP,
      PH_POLL,
      PH_DATA,
      PH_FLUSH
   } phase_type;

   // setup step codes, LBA28 sequence
   localparam logic [3:0] N_DEVICE   = 4'd0;
   localparam logic [3:0] N_FEATURES = 4'd1;
   localparam logic [3:0] N_COUNT    = 4'd2;
   localparam logic [3:0] N_LBA0     = 4'd3;
   localparam logic [3:0] N_LBA1     = 4'd4;
   localparam logic [3:0] N_LBA2     = 4'd5;
   // setup step codes, LBA48 sequence
   localparam logic [3:0] W_DEVICE   = 4'd0;
   localparam logic [3:0] W_FEATURES = 4'd1;
   localparam logic [3:0] W_COUNT_HI = 4'd2;
   localparam logic [3:0] W_LBA3     = 4'd3;
   localparam logic [3:0] W_LBA4     = 4'd4;
   localparam logic [3:0] W_LBA5     = 4'd5;
   localparam logic [3:0] W_COUNT_LO = 4'd6;
   localparam logic [3:0] W_LBA0     = 4'd7;
   localparam logic [3:0] W_LBA1     = 4'd8;
   localparam logic [3:0] W_LBA2     = 4'd9;

   phase_type         phase_ff, phase_in;
   logic [3:0]        step_ff, step_in;
   logic              is_write_ff, is_write_in;
   logic              wide_ff, wide_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SECT_W-1:0] limit_ff, limit_in;
   logic [15:0]       cbytes_ff, cbytes_in;
   logic [SECT_W-1:0] sector_ff, sector_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              has_res;
   logic              res_done;
   rsp_type           res;
   logic [3:0]        step_next;
   logic [SECT_W-1:0] sector_next;
   logic [7:0]        status;

   // one task-file write of the setup sequence
   function automatic rsp_type setup_access(input logic [15:0] base, input logic sec,
                                            input logic [3:0] step, input logic wide,
                                            input logic wr, input logic [ADDR_W-1:0] a,
                                            input logic [15:0] cb);
      logic [15:0] off;
      logic [7:0]  val;
      off = REG_CMD_STATUS;
      val = 8'h00;
      if (!wide) begin
         unique case (step)
            N_DEVICE: begin
               off = REG_DEVICE;
               val = (sec ? DEV_LBA28_SLAVE : DEV_LBA28_MASTER) | {4'h0, a[27:24]};
            end
            N_FEATURES: begin off = REG_FEATURES; val = 8'h00;     end
            N_COUNT:    begin off = REG_COUNT;    val = cb[7:0];   end
            N_LBA0:     begin off = REG_LBA_LOW;  val = a[7:0];    end
            N_LBA1:     begin off = REG_LBA_MID;  val = a[15:8];   end
            N_LBA2:     begin off = REG_LBA_HIGH; val = a[23:16];  end
            default: begin
               off = REG_CMD_STATUS;
               val = wr ? CMD_WRITE_PIO : CMD_READ_PIO;
            end
         endcase
      end else begin
         unique case (step)
            W_DEVICE: begin
               off = REG_DEVICE;
               val = sec ? DEV_LBA48_SLAVE : DEV_LBA48_MASTER;
            end
            W_FEATURES: begin off = REG_FEATURES; val = 8'h00;     end
            W_COUNT_HI: begin off = REG_COUNT;    val = cb[15:8];  end
            W_LBA3:     begin off = REG_LBA_LOW;  val = a[31:24];  end
            W_LBA4:     begin off = REG_LBA_MID;  val = a[39:32];  end
            W_LBA5:     begin off = REG_LBA_HIGH; val = a[47:40];  end
            W_COUNT_LO: begin off = REG_COUNT;    val = cb[7:0];   end
            W_LBA0:     begin off = REG_LBA_LOW;  val = a[7:0];    end
            W_LBA1:     begin off = REG_LBA_MID;  val = a[15:8];   end
            W_LBA2:     begin off = REG_LBA_HIGH; val = a[23:16];  end
            default: begin
               off = REG_CMD_STATUS;
               val = wr ? CMD_WRITE_PIO_EXT : CMD_READ_PIO_EXT;
            end
         endcase
      end
      return make_access(base, off, 1'b1, 1'b0, {8'h00, val});
   endfunction

   // a head item is taken whenever the output register can take its result
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = q_valid && out_free;

   assign step_next   = step_ff + 4'd1;
   assign sector_next = sector_ff + SECT_W'(1);
   assign status      = q_head.read_data[7:0];

   // sequencer: next access or end of transfer for the head item
   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      is_write_in = is_write_ff;
      wide_in     = wide_ff;
      addr_in     = addr_ff;
      limit_in    = limit_ff;
      cbytes_in   = cbytes_ff;
      sector_in   = sector_ff;
      word_in     = word_ff;
      has_res     = 1'b0;
      res_done    = 1'b0;
      res         = '0;

      if (q_head.is_start) begin
         if (phase_ff == PH_IDLE) begin
            has_res     = 1'b1;
            is_write_in = q_head.is_write;
            wide_in     = q_head.wide;
            if (q_head.out_of_range) begin
               res_done   = 1'b1;
               res.failed = 1'b1;
            end else begin
               addr_in   = q_head.lba;
               limit_in  = q_head.count_limit;
               cbytes_in = q_head.count_bytes;
               sector_in = '0;
               word_in   = '0;
               step_in   = '0;
               phase_in  = PH_SETUP;
               res = setup_access(io_base, secondary_drive, 4'd0, q_head.wide,
                                  q_head.is_write, q_head.lba, q_head.count_bytes);
            end
         end
      end else begin
         case (phase_ff)
            PH_SETUP: begin
               has_res = 1'b1;
               step_in = step_next;
               if (step_next < (wide_ff ? SETUP_STEPS_WIDE : SETUP_STEPS_NARROW)) begin
                  res = setup_access(io_base, secondary_drive, step_next, wide_ff,
                                     is_write_ff, addr_ff, cbytes_ff);
               end else if (sector_ff >= limit_ff) begin
                  res_done         = 1'b1;
                  res.sectors_done = limit_ff;
                  phase_in         = PH_IDLE;
               end else begin
                  res      = make_access(io_base, REG_CMD_STATUS, 1'b0, 1'b0, 16'h0000);
                  phase_in = PH_POLL;
               end
            end
            PH_POLL: begin
               has_res = 1'b1;
               if ((status & STATUS_BSY_ERR_MASK) == STATUS_BSY) begin
                  res = make_access(io_base, REG_CMD_STATUS, 1'b0, 1'b0, 16'h0000);
               end else if ((status == 8'h00) || status[0]) begin
                  res_done         = 1'b1;
                  res.failed       = 1'b1;
                  res.sectors_done = sector_ff;
                  phase_in         = PH_IDLE;
               end else begin
                  word_in  = '0;
                  phase_in = PH_DATA;
                  res = make_access(io_base, REG_DATA, is_write_ff, 1'b1, q_head.fill_word);
                  res.fill_taken = is_write_ff;
               end
            end
            PH_DATA: begin
               has_res = 1'b1;
               word_in = word_ff + WORD_W'(1);
               if (word_ff != WORD_W'(WORDS_PER_SECTOR - 1)) begin
                  res = make_access(io_base, REG_DATA, is_write_ff, 1'b1, q_head.fill_word);
                  res.fill_taken = is_write_ff;
               end else if (is_write_ff) begin
                  res = make_access(io_base, REG_CMD_STATUS, 1'b1, 1'b0,
                                    {8'h00, wide_ff ? CMD_FLUSH_EXT : CMD_FLUSH});
                  phase_in = PH_FLUSH;
               end else begin
                  sector_in = sector_next;
                  if (sector_next >= limit_ff) begin
                     res_done         = 1'b1;
                     res.sectors_done = limit_ff;
                     phase_in         = PH_IDLE;
                  end else begin
                     res      = make_access(io_base, REG_CMD_STATUS, 1'b0, 1'b0, 16'h0000);
                     phase_in = PH_POLL;
                  end
               end
               // read words go to the host with whatever access follows
               if (!is_write_ff) begin
                  res.host_word_valid = 1'b1;
                  res.host_word       = q_head.read_data;
               end
            end
            PH_FLUSH: begin
               has_res   = 1'b1;
               sector_in = sector_next;
               if (sector_next >= limit_ff) begin
                  res_done         = 1'b1;
                  res.sectors_done = limit_ff;
                  phase_in         = PH_IDLE;
               end else begin
                  res      = make_access(io_base, REG_CMD_STATUS, 1'b0, 1'b0, 16'h0000);
                  phase_in = PH_POLL;
               end
            end
            default: begin
               has_res = 1'b0;
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      if (q_pop) begin
         rsp_valid_in = has_res;
         rsp_last_in  = res_done;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         step_ff      <= '0;
         is_write_ff  <= 1'b0;
         wide_ff      <= 1'b0;
         sector_ff    <= '0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff    <= phase_in;
            step_ff     <= step_in;
            is_write_ff <= is_write_in;
            wide_ff     <= wide_in;
            sector_ff   <= sector_in;
            word_ff     <= word_in;
            addr_ff     <= addr_in;
            limit_ff    <= limit_in;
            cbytes_ff   <= cbytes_in;
         end
      end
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
